// ===== rtl/u16d_pkg.sv =====
// Package for the UTF-16 to UCS-4 decoder: shared types and constants.
// No dependencies; the decoder unit and the step module import it.
package u16d_pkg;

  localparam logic [1:0] STATUS_CHAR     = 2'd0;
  localparam logic [1:0] STATUS_BAD_PAIR = 2'd1;
  localparam logic [1:0] STATUS_TRUNC    = 2'd2;

  localparam logic [7:0] BOM_BYTE_FE = 8'hFE;
  localparam logic [7:0] BOM_BYTE_FF = 8'hFF;

  localparam logic [7:0] SURR_HIGH_MIN = 8'hD8;
  localparam logic [7:0] SURR_HIGH_MAX = 8'hDB;
  localparam logic [7:0] SURR_LOW_MIN  = 8'hDC;
  localparam logic [7:0] SURR_LOW_MAX  = 8'hDF;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0] REG_DEFAULT_BIG_ENDIAN = 1'b0;

  typedef struct packed {
    logic [1:0]  phase;
    logic [23:0] pending;
    logic        big_endian;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [20:0] code_point;
    logic [1:0]  status;
  } dec_result_t;

endpackage

// ===== rtl/u16d_if.sv =====
// Handshake channels of the UTF-16 decoder: the byte stream and the code point stream.
// Depends on nothing; the top level uses the sink of one and the source of the other.
interface u16d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface u16d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;

  modport source(output valid, output code_point, output status, input ready);
  modport sink(input valid, input code_point, input status, output ready);
endinterface

// ===== rtl/utf16_to_ucs4_decoder_unit.sv =====
// The decoder takes one byte of a UTF-16 stream per cycle and gives at most one UCS-4 word
// per byte, in the cycle after the byte is taken; the single result register sets this rate, and
// bytes keep flowing as long as that register is empty or its word is taken in the same cycle.
// Byte order starts from the default_big_endian register and follows any byte order mark.
module utf16_to_ucs4_decoder_unit
  import u16d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  u16d_byte_if.sink             bytes,
  u16d_cp_if.source             points,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [1:0]  phase;
  logic [23:0] pending;
  logic        big_endian;
  logic        default_big_endian;
  logic        res_valid;
  logic [20:0] res_code_point;
  logic [1:0]  res_status;

  dec_state_t  cur;
  dec_state_t  nxt;
  dec_result_t res;
  logic        accept;
  logic        cfg_write;
  logic        reg_hit;

  assign cur.phase      = phase;
  assign cur.pending    = pending;
  assign cur.big_endian = big_endian;

  u16d_step u_step (
    .cur       (cur),
    .data_byte (bytes.data_byte),
    .last_byte (bytes.last_byte),
    .nxt       (nxt),
    .res       (res)
  );

  assign bytes.ready = !res_valid || points.ready;
  assign accept      = bytes.valid && bytes.ready;

  assign reg_hit   = paddr[CFG_ADDR_W-1:2] == REG_DEFAULT_BIG_ENDIAN;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? {31'b0, default_big_endian} : 32'b0;

  assign points.valid      = res_valid;
  assign points.code_point = res_code_point;
  assign points.status     = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= 2'd0;
      big_endian         <= 1'b1;
      default_big_endian <= 1'b1;
      res_valid          <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= nxt.phase;
        res_valid <= res.valid;
      end else if (points.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_write) begin
        default_big_endian <= pwdata[0];
        big_endian         <= pwdata[0];
      end else if (accept) begin
        big_endian <= nxt.big_endian;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending <= nxt.pending;
      if (res.valid) begin
        res_code_point <= res.code_point;
        res_status     <= res.status;
      end
    end
  end

`ifndef SYNTHESIS
  a_error_zero_cp: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != STATUS_CHAR |-> res_code_point == 21'd0)
    else $error("error word carries a nonzero code point");

  a_last_clears_phase: assert property (@(posedge clk) disable iff (rst)
    accept && bytes.last_byte |=> phase == 2'd0)
    else $error("byte phase not cleared after the last byte");

  a_trunc_reported: assert property (@(posedge clk) disable iff (rst)
    accept && bytes.last_byte && (phase == 2'd0 || phase == 2'd2)
      |=> res_valid && res_status == STATUS_TRUNC)
    else $error("truncated stream not reported");

  a_first_byte_held: assert property (@(posedge clk) disable iff (rst)
    accept && !bytes.last_byte && phase == 2'd0 |=> phase == 2'd1 && !res_valid)
    else $error("first byte of a unit not held");

  a_pair_word: assert property (@(posedge clk) disable iff (rst)
    accept && phase == 2'd3 |=> res_valid && res_status != STATUS_TRUNC)
    else $error("surrogate pair produced no word");
`endif

endmodule

// ===== rtl/u16d_step.sv =====
// Next-state and result logic for one byte of the UTF-16 decoder.
// Depends on u16d_pkg for the state and result structs and the surrogate constants.
module u16d_step
  import u16d_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output dec_state_t  nxt,
  output dec_result_t res
);

  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  unit_hi;
  logic [7:0]  unit_lo;
  logic [7:0]  h0;
  logic [7:0]  h1;
  logic [7:0]  l0;
  logic [7:0]  l1;
  logic [7:0]  h0_off;
  logic [7:0]  l0_off;
  logic [20:0] pair_cp;

  assign byte0 = cur.pending[7:0];
  assign byte1 = cur.pending[15:8];
  assign byte2 = cur.pending[23:16];

  assign unit_hi = cur.big_endian ? byte0 : data_byte;
  assign unit_lo = cur.big_endian ? data_byte : byte0;

  assign h0 = cur.big_endian ? byte0 : byte1;
  assign h1 = cur.big_endian ? byte1 : byte0;
  assign l0 = cur.big_endian ? byte2 : data_byte;
  assign l1 = cur.big_endian ? data_byte : byte2;

  assign h0_off = h0 - SURR_HIGH_MIN;
  assign l0_off = l0 - SURR_LOW_MIN;

  assign pair_cp = {h0_off[2:0], 18'b0} + {3'b0, h1, 10'b0} + {11'b0, l0_off[1:0], 8'b0}
                 + {13'b0, l1} + SUPP_BASE;

  always_comb begin
    nxt = cur;
    res.valid      = 1'b0;
    res.code_point = '0;
    res.status     = STATUS_CHAR;
    unique case (cur.phase)
      2'd0: begin
        nxt.pending[7:0] = data_byte;
        nxt.phase = 2'd1;
      end
      2'd1: begin
        if (byte0 == BOM_BYTE_FE && data_byte == BOM_BYTE_FF) begin
          nxt.big_endian = 1'b1;
          nxt.phase = 2'd0;
        end else if (byte0 == BOM_BYTE_FF && data_byte == BOM_BYTE_FE) begin
          nxt.big_endian = 1'b0;
          nxt.phase = 2'd0;
        end else if (unit_hi >= SURR_HIGH_MIN && unit_hi <= SURR_HIGH_MAX) begin
          nxt.pending[15:8] = data_byte;
          nxt.phase = 2'd2;
        end else begin
          res.valid      = 1'b1;
          res.code_point = {5'b0, unit_hi, unit_lo};
          nxt.phase = 2'd0;
        end
      end
      2'd2: begin
        nxt.pending[23:16] = data_byte;
        nxt.phase = 2'd3;
      end
      default: begin
        res.valid = 1'b1;
        if (l0 < SURR_LOW_MIN || l0 > SURR_LOW_MAX) begin
          res.status = STATUS_BAD_PAIR;
        end else begin
          res.code_point = pair_cp;
        end
        nxt.phase = 2'd0;
      end
    endcase

    if (last_byte && nxt.phase != 2'd0) begin
      nxt.phase      = 2'd0;
      res.valid      = 1'b1;
      res.code_point = '0;
      res.status     = STATUS_TRUNC;
    end
  end

endmodule
